FILE: design/fraction_accumulator_reduce_top_assert.svh
// Assertion macros shared by the fraction accumulator RTL.
`ifndef FRACTION_ACCUMULATOR_REDUCE_TOP_ASSERT_SVH
`define FRACTION_ACCUMULATOR_REDUCE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define FAR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");
// Expression must never be true at a rising edge outside reset.
`define FAR_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define FAR_ASSERT(lbl, clk, rstn, prop)
`define FAR_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: design/fa_pkg.sv
// Package with types and constants of the fraction accumulator.
`timescale 1ns / 1ps
package fa_pkg;

  localparam int FA_VALUE_WIDTH = 32;  // default accumulator width
  localparam int FA_FIELD_W     = 32;  // width of the numeric port fields
  localparam int FA_CHUNK_W     = 32;  // operand chunk of the shared multiplier

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_FINISH = 3'd5
  } fa_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_DIVN,
    ST_DIVD,
    ST_EMIT
  } fa_state_e;

  // Which product of an arithmetic item the multiplier is working on.
  typedef enum logic [1:0] {
    PR_FIRST,
    PR_SECOND,
    PR_DENOM
  } fa_prod_e;

  typedef struct packed {
    logic [2:0]                   opcode;
    logic signed [FA_FIELD_W-1:0] in_numer;
    logic signed [FA_FIELD_W-1:0] in_denom;
  } fa_in_t;

  typedef struct packed {
    logic signed [FA_FIELD_W-1:0] out_numer;
    logic signed [FA_FIELD_W-1:0] out_denom;
  } fa_out_t;

endpackage

FILE: design/fa_mul.sv
// Iterative multiplier giving the low bits of an unsigned product, chunk by chunk.
`timescale 1ns / 1ps
module fa_mul
  import fa_pkg::*;
#(
  parameter int VALUE_WIDTH = FA_VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] product_o
);

  localparam int CW   = FA_CHUNK_W;
  localparam int NCH  = (VALUE_WIDTH + CW - 1) / CW;
  localparam int PADW = NCH * CW;
  localparam int IW   = (NCH > 1) ? $clog2(NCH) : 1;

  logic [PADW-1:0]   a_q, b_q;
  logic [IW-1:0]     i_q, j_q;
  logic              issue_q, ppv_q, last_q;
  logic [2*CW-1:0]   pp_q;
  logic [IW:0]       sh_q;
  logic [VALUE_WIDTH-1:0] acc_q;

  logic              last_pair;
  logic [2*PADW-1:0] wide;
  logic [VALUE_WIDTH-1:0] term;

  assign last_pair = (i_q == IW'(NCH - 1)) && (j_q == IW'(NCH - 1));
  assign wide      = (2 * PADW)'(pp_q) << (sh_q * CW);
  assign term      = wide[VALUE_WIDTH-1:0];
  assign done_o    = ppv_q & last_q;
  assign product_o = acc_q + term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      ppv_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      ppv_q  <= issue_q;
      last_q <= issue_q & last_pair;
      if (start_i && !issue_q && !ppv_q) begin
        issue_q <= 1'b1;
      end else if (issue_q && last_pair) begin
        issue_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !issue_q && !ppv_q) begin
      a_q   <= PADW'(a_i);
      b_q   <= PADW'(b_i);
      i_q   <= '0;
      j_q   <= '0;
      acc_q <= '0;
    end else begin
      if (issue_q) begin
        pp_q <= a_q[i_q*CW +: CW] * b_q[j_q*CW +: CW];
        sh_q <= {1'b0, i_q} + {1'b0, j_q};
        if (j_q == IW'(NCH - 1)) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      if (ppv_q) begin
        acc_q <= acc_q + term;
      end
    end
  end

endmodule

FILE: design/fa_div.sv
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
`timescale 1ns / 1ps
module fa_div
  import fa_pkg::*;
#(
  parameter int VALUE_WIDTH = FA_VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quot_o,
  output logic [VALUE_WIDTH-1:0] rem_o
);

  localparam int CNTW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] quot_q, rem_q, dvsr_q;
  logic [CNTW-1:0]        cnt_q;
  logic                   run_q, done_q;
  logic [VALUE_WIDTH:0]   trial, diff;

  assign trial  = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign diff   = trial - {1'b0, dvsr_q};
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (start_i && !run_q) begin
        run_q <= 1'b1;
        cnt_q <= CNTW'(VALUE_WIDTH - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !run_q) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (run_q) begin
      // A clear top bit of the difference means the divisor fits.
      if (!diff[VALUE_WIDTH]) begin
        rem_q  <= diff[VALUE_WIDTH-1:0];
        quot_q <= {quot_q[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_q  <= trial[VALUE_WIDTH-1:0];
        quot_q <= {quot_q[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: design/fraction_accumulator_reduce_top.sv
`timescale 1ns / 1ps
// Top level of the fraction accumulator. The block keeps a running fraction
// of VALUE_WIDTH-bit two's complement numerator and denominator, reset to 0/1.
// Each input transfer carries an opcode and an operand fraction: load sets the
// fraction (a load of 0/0 sets 0/1 and returns 0/1 as a result), add and
// subtract cross-multiply onto the product of the denominators, multiply and
// divide multiply straight or crosswise, and all of these wrap at VALUE_WIDTH
// bits without reducing. Finish reduces the fraction by the gcd of the
// numerator magnitude and the denominator when the denominator is positive,
// stores it and returns it as a result transfer; opcodes six and seven are
// dropped. One item is worked on at a time and in_stall_o is high until it is
// done. All products go through one shared multiplier that forms NCH*NCH
// chunk products per product, NCH being VALUE_WIDTH/32 rounded up; add and
// subtract use three products in turn, multiply and divide two. A load other
// than 0/0 and an ignored opcode leave the block idle, while a load of 0/0
// passes through the emit state. Finish uses one shared restoring divider:
// one division per Euclid step of the gcd plus two for the final quotients;
// with a denominator that is not positive it goes straight to the emit state.
// The result sits in an output register, so a new item is taken while it
// waits; only a further result must wait for that register to drain.
`include "fraction_accumulator_reduce_top_assert.svh"
module fraction_accumulator_reduce_top
  import fa_pkg::*;
#(
  parameter int VALUE_WIDTH = FA_VALUE_WIDTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  fa_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output fa_out_t out_data_o
);

  localparam int W = VALUE_WIDTH;

  fa_state_e state_q, state_d;
  fa_prod_e  pidx_q, pidx_d;
  fa_op_e    op_q, op_d, in_op;
  logic      wait_q, wait_d;
  logic      out_valid_q, out_valid_d;
  fa_out_t   out_q;

  // Architectural accumulator.
  logic [W-1:0] acc_n_q, acc_n_d, acc_d_q, acc_d_d;
  // Operand and intermediate registers.
  logic [W-1:0] bn_q, bn_d, bd_q, bd_d;
  logic [W-1:0] p0_q, p0_d, p1_q, p1_d;
  logic [W-1:0] ga_q, ga_d, gb_q, gb_d, mag_q, mag_d;
  logic         neg_q, neg_d;

  logic [W-1:0] bn_in, bd_in;
  logic         in_acc, load_zero, fin_reduce, out_free, out_load;

  logic         mul_start, mul_done;
  logic [W-1:0] mul_a, mul_b, mul_prod;
  logic         div_start, div_done;
  logic [W-1:0] div_a, div_b, div_quot, div_rem;

  // Operand fields are taken in their low W bits, or sign-extended when wider.
  assign bn_in      = W'(in_data_i.in_numer);
  assign bd_in      = W'(in_data_i.in_denom);
  assign in_op      = fa_op_e'(in_data_i.opcode);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_zero  = (bn_in == '0) && (bd_in == '0);
  // Reduction only applies to a strictly positive denominator.
  assign fin_reduce = (acc_d_q != '0) && !acc_d_q[W-1];
  assign out_free   = !out_valid_q || !out_stall_i;

  fa_mul #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .done_o   (mul_done),
    .product_o(mul_prod)
  );

  fa_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_LOAD: begin
              if (load_zero) begin
                state_d = ST_EMIT;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_d = ST_MUL;
            OP_FINISH: state_d = fin_reduce ? ST_MOD : ST_EMIT;
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        if (mul_done && (pidx_q == PR_DENOM)) begin
          state_d = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (gb_q == '0) begin
          state_d = ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (div_done) begin
          state_d = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    op_d      = op_q;
    pidx_d    = pidx_q;
    wait_d    = wait_q;
    acc_n_d   = acc_n_q;
    acc_d_d   = acc_d_q;
    bn_d      = bn_q;
    bd_d      = bd_q;
    p0_d      = p0_q;
    p1_d      = p1_q;
    ga_d      = ga_q;
    gb_d      = gb_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    mul_start = 1'b0;
    mul_a     = acc_n_q;
    mul_b     = bd_q;
    div_start = 1'b0;
    div_a     = ga_q;
    div_b     = gb_q;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d   = in_op;
          bn_d   = bn_in;
          bd_d   = bd_in;
          pidx_d = PR_FIRST;
          wait_d = 1'b0;
          case (in_op)
            OP_LOAD: begin
              if (load_zero) begin
                acc_n_d = '0;
                acc_d_d = W'(1);
              end else begin
                acc_n_d = bn_in;
                acc_d_d = bd_in;
              end
            end
            OP_FINISH: begin
              neg_d = acc_n_q[W-1];
              mag_d = acc_n_q[W-1] ? ('0 - acc_n_q) : acc_n_q;
              ga_d  = acc_n_q[W-1] ? ('0 - acc_n_q) : acc_n_q;
              gb_d  = acc_d_q;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        case (pidx_q)
          PR_FIRST: begin
            mul_a = acc_n_q;
            mul_b = (op_q == OP_MUL) ? bn_q : bd_q;
          end
          PR_SECOND: begin
            mul_a = bn_q;
            mul_b = acc_d_q;
          end
          PR_DENOM: begin
            mul_a = acc_d_q;
            mul_b = (op_q == OP_DIV) ? bn_q : bd_q;
          end
          default: ;
        endcase
        if (!wait_q) begin
          mul_start = 1'b1;
          wait_d    = 1'b1;
        end
        if (mul_done) begin
          wait_d = 1'b0;
          case (pidx_q)
            PR_FIRST: begin
              p0_d   = mul_prod;
              pidx_d = ((op_q == OP_ADD) || (op_q == OP_SUB)) ? PR_SECOND : PR_DENOM;
            end
            PR_SECOND: begin
              p1_d   = mul_prod;
              pidx_d = PR_DENOM;
            end
            PR_DENOM: begin
              acc_d_d = mul_prod;
              case (op_q)
                OP_ADD:  acc_n_d = p0_q + p1_q;
                OP_SUB:  acc_n_d = p0_q - p1_q;
                default: acc_n_d = p0_q;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        div_a = ga_q;
        div_b = gb_q;
        if ((gb_q != '0) && !wait_q) begin
          div_start = 1'b1;
          wait_d    = 1'b1;
        end
        if (div_done) begin
          wait_d = 1'b0;
          ga_d   = gb_q;
          gb_d   = div_rem;
        end
      end
      ST_DIVN: begin
        div_a = mag_q;
        div_b = ga_q;
        if (!wait_q) begin
          div_start = 1'b1;
          wait_d    = 1'b1;
        end
        if (div_done) begin
          wait_d = 1'b0;
          mag_d  = div_quot;
        end
      end
      ST_DIVD: begin
        div_a = acc_d_q;
        div_b = ga_q;
        if (!wait_q) begin
          div_start = 1'b1;
          wait_d    = 1'b1;
        end
        if (div_done) begin
          wait_d  = 1'b0;
          acc_d_d = div_quot;
          acc_n_d = neg_q ? ('0 - mag_q) : mag_q;
        end
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pidx_q      <= PR_FIRST;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      acc_n_q     <= '0;
      acc_d_q     <= W'(1);
    end else begin
      state_q     <= state_d;
      pidx_q      <= pidx_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
      acc_n_q     <= acc_n_d;
      acc_d_q     <= acc_d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    bn_q  <= bn_d;
    bd_q  <= bd_d;
    p0_q  <= p0_d;
    p1_q  <= p1_d;
    ga_q  <= ga_d;
    gb_q  <= gb_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    // The result is the accumulator itself, widened or cut to the port width.
    if (out_load) begin
      out_q.out_numer <= FA_FIELD_W'($signed(acc_n_q));
      out_q.out_denom <= FA_FIELD_W'($signed(acc_d_q));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A finish transfer always leaves the idle state, with or without reduction.
  `FAR_ASSERT(a_finish_leaves_idle, clk_i, rst_ni, (in_acc && (in_op == OP_FINISH)) |=> (state_q != ST_IDLE))
  // The accumulator only moves when an item is taken or worked on.
  `FAR_ASSERT(a_acc_holds_idle, clk_i, rst_ni, ((state_q == ST_IDLE) && !in_acc) |=> $stable(acc_d_q))
  // A new result only appears out of the emit state.
  `FAR_ASSERT(a_result_from_emit, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == ST_EMIT))
  // The gcd used for the final divisions is never zero.
  `FAR_ASSERT_NEVER(a_gcd_nonzero, clk_i, rst_ni, (state_q == ST_DIVN) && (ga_q == '0))

endmodule
